[rtl/obdcan_pkg.sv]
// Package for the OBD CAN protocol detector: transaction payload types,
// configuration register set, codes and reset values. No dependencies.
`default_nettype none

package obdcan_pkg;

    // Input operation codes.
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_FRAME   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Link status codes.
    localparam logic [1:0] LINK_MATCHING = 2'd0;
    localparam logic [1:0] LINK_MATCHED  = 2'd1;
    localparam logic [1:0] LINK_FAILED   = 2'd2;

    // Protocol codes, shared by the trial register and the detected output.
    localparam logic [2:0] PROTO_NONE   = 3'd0;
    localparam logic [2:0] PROTO_J1939  = 3'd1;
    localparam logic [2:0] PROTO_11_250 = 3'd2;
    localparam logic [2:0] PROTO_29_250 = 3'd3;
    localparam logic [2:0] PROTO_11_500 = 3'd4;
    localparam logic [2:0] PROTO_29_500 = 3'd5;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONLY_J1939   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TMO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_J1939_GRACE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_J1939_LISTEN = 3'd4;

    // Frame content constants.
    localparam logic [15:0] PGN_F004      = 16'hF004;
    localparam logic [7:0]  SVC_MODE01_OK = 8'h41;
    localparam logic [7:0]  PID_SUPPORTED = 8'h00;
    localparam logic [7:0]  WAIT_MAX      = 8'hFF;
    localparam logic [3:0]  TIMEOUT_MAX   = 4'hF;

    typedef struct packed {
        logic [1:0]  op;
        logic        from_obd_port;
        logic [28:0] frame_id;
        logic        frame_extended;
        logic [7:0]  data_byte1;
        logic [7:0]  data_byte2;
        logic        id_blacklisted;
    } item_t;

    typedef struct packed {
        logic [1:0] link_status;
        logic [2:0] detected_protocol;
        logic       baud_is_500;
        logic       baud_program;
        logic       send_request;
        logic       request_extended;
    } result_t;

    typedef struct packed {
        logic       only_j1939_cfg;
        logic [7:0] reply_timeout;
        logic [3:0] retry_limit;
        logic [7:0] j1939_grace;
        logic [7:0] j1939_listen;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        only_j1939_cfg: 1'b0,
        reply_timeout:  8'd10,
        retry_limit:    4'd3,
        j1939_grace:    8'd40,
        j1939_listen:   8'd30
    };

endpackage

`default_nettype wire

[rtl/obdcan_core.sv]
// Detection sequencer: holds the matching state and computes the next state
// and the result of one transaction. Depends on obdcan_pkg.
`default_nettype none

module obdcan_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               adv,
    input  wire obdcan_pkg::item_t  item,
    input  wire obdcan_pkg::cfg_t   cfg,
    output obdcan_pkg::result_t     result
);

    typedef enum logic [1:0] {
        PH_INIT   = 2'd0,
        PH_SEND   = 2'd1,
        PH_WAIT   = 2'd2,
        PH_LISTEN = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  trial_reg, trial_next;
    logic        baud_reg, baud_next;
    logic        seen_reg, seen_next;
    logic [7:0]  wait_reg, wait_next;
    logic [3:0]  tmo_reg, tmo_next;
    logic        reply_reg, reply_next;
    logic [1:0]  link_reg, link_next;
    logic        learned_reg, learned_next;

    logic        only_mode;
    logic        is_f004;
    logic        reply_ok;
    logic        prog;
    logic        req;
    logic        req_ext;
    logic [7:0]  wait_bumped;
    logic [3:0]  tmo_bumped;
    logic [1:0]  match_code;

    // Evidence decode and saturating counter values.
    always_comb begin
        only_mode   = cfg.only_j1939_cfg | learned_reg;
        is_f004     = item.frame_extended && (item.frame_id[23:8] == obdcan_pkg::PGN_F004);
        reply_ok    = (item.data_byte1 == obdcan_pkg::SVC_MODE01_OK)
                   && (item.data_byte2 == obdcan_pkg::PID_SUPPORTED)
                   && !(item.frame_extended && item.id_blacklisted);
        wait_bumped = (wait_reg == obdcan_pkg::WAIT_MAX) ? wait_reg : wait_reg + 8'd1;
        tmo_bumped  = (tmo_reg == obdcan_pkg::TIMEOUT_MAX) ? tmo_reg : tmo_reg + 4'd1;
        // A match on an unknown trial code without J1939 evidence fails.
        if (seen_reg || (trial_reg >= obdcan_pkg::PROTO_11_250
                         && trial_reg <= obdcan_pkg::PROTO_29_500)) begin
            match_code = obdcan_pkg::LINK_MATCHED;
        end else begin
            match_code = obdcan_pkg::LINK_FAILED;
        end
    end

    // Next state for one transaction.
    always_comb begin
        phase_next   = phase_reg;
        trial_next   = trial_reg;
        baud_next    = baud_reg;
        seen_next    = seen_reg;
        wait_next    = wait_reg;
        tmo_next     = tmo_reg;
        reply_next   = reply_reg;
        link_next    = link_reg;
        learned_next = learned_reg;
        prog         = 1'b0;
        req          = 1'b0;
        req_ext      = 1'b0;

        if (adv) begin
            if (item.op == obdcan_pkg::OP_RESTART) begin
                phase_next   = PH_INIT;
                trial_next   = obdcan_pkg::PROTO_11_250;
                baud_next    = 1'b0;
                seen_next    = 1'b0;
                wait_next    = '0;
                tmo_next     = '0;
                reply_next   = 1'b0;
                link_next    = obdcan_pkg::LINK_MATCHING;
                learned_next = 1'b0;
            end else if (link_reg == obdcan_pkg::LINK_MATCHING
                         && item.op == obdcan_pkg::OP_TICK) begin
                unique case (phase_reg)
                    PH_INIT: begin
                        if (only_mode) begin
                            baud_next = 1'b0;
                        end
                        prog       = 1'b1;
                        tmo_next   = '0;
                        reply_next = 1'b0;
                        phase_next = (trial_reg == obdcan_pkg::PROTO_11_250) ? PH_LISTEN
                                                                              : PH_SEND;
                    end
                    PH_SEND: begin
                        if (!only_mode) begin
                            req     = 1'b1;
                            req_ext = !(trial_reg == obdcan_pkg::PROTO_11_250
                                        || trial_reg == obdcan_pkg::PROTO_11_500);
                        end
                        phase_next = PH_WAIT;
                        wait_next  = '0;
                    end
                    PH_WAIT: begin
                        if (reply_reg) begin
                            // At 250k, hold off a while in case J1939 shows up.
                            if (!baud_reg && !seen_reg) begin
                                wait_next = wait_bumped;
                                if (wait_bumped > cfg.j1939_grace) begin
                                    link_next = match_code;
                                end
                            end else begin
                                link_next = match_code;
                            end
                        end else if (wait_reg > cfg.reply_timeout) begin
                            tmo_next = tmo_bumped;
                            if (tmo_bumped >= cfg.retry_limit) begin
                                // Next variant; J1939 or the last ends it.
                                case (trial_reg)
                                    obdcan_pkg::PROTO_11_250: begin
                                        trial_next = obdcan_pkg::PROTO_29_250;
                                        baud_next  = 1'b0;
                                        phase_next = PH_INIT;
                                    end
                                    obdcan_pkg::PROTO_29_250: begin
                                        if (seen_reg) begin
                                            trial_next = obdcan_pkg::PROTO_NONE;
                                            link_next  = obdcan_pkg::LINK_MATCHED;
                                        end else begin
                                            trial_next = obdcan_pkg::PROTO_11_500;
                                            baud_next  = 1'b1;
                                            phase_next = PH_INIT;
                                        end
                                    end
                                    obdcan_pkg::PROTO_11_500: begin
                                        trial_next = obdcan_pkg::PROTO_29_500;
                                        baud_next  = 1'b1;
                                        phase_next = PH_INIT;
                                    end
                                    default: begin
                                        link_next = obdcan_pkg::LINK_FAILED;
                                    end
                                endcase
                            end else begin
                                phase_next = PH_SEND;
                            end
                        end else begin
                            wait_next = wait_bumped;
                        end
                    end
                    PH_LISTEN: begin
                        wait_next = wait_bumped;
                        if (wait_bumped > cfg.j1939_listen) begin
                            tmo_next   = '0;
                            reply_next = 1'b0;
                            phase_next = PH_SEND;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end else if (link_reg == obdcan_pkg::LINK_MATCHING
                         && item.op == obdcan_pkg::OP_FRAME && item.from_obd_port) begin
                // Frames count only while waiting for a reply or listening.
                if (phase_reg == PH_WAIT) begin
                    if (!baud_reg && is_f004) begin
                        seen_next = 1'b1;
                    end
                    if (reply_ok) begin
                        wait_next  = '0;
                        reply_next = 1'b1;
                    end
                end else if (phase_reg == PH_LISTEN) begin
                    if (!baud_reg && is_f004) begin
                        seen_next    = 1'b1;
                        trial_next   = obdcan_pkg::PROTO_NONE;
                        learned_next = 1'b1;
                        link_next    = obdcan_pkg::LINK_MATCHED;
                    end
                end
            end
        end
    end

    // Result of the transaction, taken from the updated state.
    always_comb begin
        result.link_status = link_next;
        if (link_next == obdcan_pkg::LINK_MATCHED) begin
            result.detected_protocol = seen_next ? obdcan_pkg::PROTO_J1939 : trial_next;
        end else begin
            result.detected_protocol = obdcan_pkg::PROTO_NONE;
        end
        result.baud_is_500      = baud_next;
        result.baud_program     = prog;
        result.send_request     = req;
        result.request_extended = req_ext;
    end

    // Matching state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_INIT;
            trial_reg   <= obdcan_pkg::PROTO_11_250;
            baud_reg    <= 1'b0;
            seen_reg    <= 1'b0;
            wait_reg    <= '0;
            tmo_reg     <= '0;
            reply_reg   <= 1'b0;
            link_reg    <= obdcan_pkg::LINK_MATCHING;
            learned_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            trial_reg   <= trial_next;
            baud_reg    <= baud_next;
            seen_reg    <= seen_next;
            wait_reg    <= wait_next;
            tmo_reg     <= tmo_next;
            reply_reg   <= reply_next;
            link_reg    <= link_next;
            learned_reg <= learned_next;
        end
    end

    // Once decided, the link stays decided until a restart transaction.
    a_link_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        link_reg != obdcan_pkg::LINK_MATCHING && !(adv && item.op == obdcan_pkg::OP_RESTART)
        |=> $stable(link_reg))
        else $error("link status changed without a restart");

    // Learned J1939-only mode implies J1939 evidence.
    a_learned_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        learned_reg |-> seen_reg && link_reg == obdcan_pkg::LINK_MATCHED)
        else $error("J1939-only mode learned without a J1939 match");

    // The 250k variants are only tried with the 250k baud selected.
    a_baud_trial: assert property (@(posedge aclk) disable iff (!aresetn)
        (trial_reg == obdcan_pkg::PROTO_11_250 || trial_reg == obdcan_pkg::PROTO_29_250)
        |-> !baud_reg)
        else $error("250k variant on the 500k baud");

endmodule

`default_nettype wire

[rtl/obd_can_protocol_detector_unit.sv]
// A result is registered and appears in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle; the sequencer updates in a single pass
// and the result register frees as it is taken, so a held result stalls input.
// Reset: synchronous active-low aresetn restores the configuration registers
// to their defaults and the sequencer to 11-bit/250k matching; no result waits.
// Top level of the OBD CAN protocol detector. Depends on obdcan_pkg, obdcan_core.
`default_nettype none

module obd_can_protocol_detector_unit (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire obdcan_pkg::item_t                     s_data,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output obdcan_pkg::result_t                        m_data,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [obdcan_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [7:0]                            cfg_data
);

    obdcan_pkg::cfg_t    cfg_reg, cfg_next;
    obdcan_pkg::result_t result_reg;
    obdcan_pkg::result_t step_result;
    logic                valid_reg, valid_next;
    logic                s_fire;

    // Input is taken whenever the result register is empty or being drained.
    assign s_ready   = !valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = valid_reg;
    assign m_data    = result_reg;

    obdcan_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (s_fire),
        .item    (s_data),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    // Configuration register writes; unknown indexes are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                obdcan_pkg::CFG_ONLY_J1939:   cfg_next.only_j1939_cfg = cfg_data[0];
                obdcan_pkg::CFG_REPLY_TMO:    cfg_next.reply_timeout  = cfg_data;
                obdcan_pkg::CFG_RETRY_LIMIT:  cfg_next.retry_limit    = cfg_data[3:0];
                obdcan_pkg::CFG_J1939_GRACE:  cfg_next.j1939_grace    = cfg_data;
                obdcan_pkg::CFG_J1939_LISTEN: cfg_next.j1939_listen   = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    // Result register occupancy.
    always_comb begin
        if (s_fire) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg   <= obdcan_pkg::CFG_RESET;
            valid_reg <= 1'b0;
        end else begin
            cfg_reg   <= cfg_next;
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            result_reg <= step_result;
        end
    end

    // Every accepted transaction yields a result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid)
        else $error("accepted transaction produced no result");

    // A protocol is reported only with a matched link.
    a_proto_matched: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.detected_protocol != obdcan_pkg::PROTO_NONE
        |-> m_data.link_status == obdcan_pkg::LINK_MATCHED)
        else $error("protocol reported without a match");

    // The request frame format is only given with a request strobe.
    a_req_ext: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.request_extended |-> m_data.send_request)
        else $error("extended request flag without request");

    // A restart brings the link back to matching at 250k.
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_data.op == obdcan_pkg::OP_RESTART
        |=> m_data.link_status == obdcan_pkg::LINK_MATCHING && !m_data.baud_is_500)
        else $error("restart did not reinitialize detection");

endmodule

`default_nettype wire

[tb/sv/obd_can_protocol_detector_unit_tb.sv]
// Self-checking testbench for obd_can_protocol_detector_unit: directed items, then several
// configuration settings with random tick, frame and restart traffic under random flow control.
// Depends on obdcan_pkg and the detector RTL.

module obd_can_protocol_detector_unit_tb;

    import obdcan_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 300000;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    // Sequencer phases of the detector.
    typedef enum logic [1:0] {PH_INIT, PH_SEND, PH_WAIT, PH_LISTEN} seq_phase_t;

    // Receiver flow-control modes.
    typedef enum logic [1:0] {RDY_ALWAYS, RDY_MOSTLY, RDY_THIRD, RDY_HALF} ready_mode_t;

    // Tracks the detection sequence and holds the link status expected for each
    // accepted transaction until the block returns it.
    class protocol_tracker;
        cfg_t        cfg;
        seq_phase_t  phase;
        logic [2:0]  trial;
        logic        baud;
        logic        j1939_hit;
        logic [7:0]  wait_cnt;
        logic [3:0]  tmo_cnt;
        logic        reply_hit;
        logic [1:0]  link;
        logic        learned_only;
        result_t     status_due[$];
        int unsigned mismatches;
        int unsigned n_items;
        int unsigned n_results;
        int unsigned n_matched;
        int unsigned n_failed;
        int unsigned n_requests;

        function new();
            cfg = CFG_RESET;
            mismatches = 0;
            n_items = 0;
            n_results = 0;
            n_matched = 0;
            n_failed = 0;
            n_requests = 0;
            clear_seq();
        endfunction

        function void clear_seq();
            phase = PH_INIT;
            trial = PROTO_11_250;
            baud = 1'b0;
            j1939_hit = 1'b0;
            wait_cnt = '0;
            tmo_cnt = '0;
            reply_hit = 1'b0;
            link = LINK_MATCHING;
            learned_only = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_ONLY_J1939:   cfg.only_j1939_cfg = val[0];
                CFG_REPLY_TMO:    cfg.reply_timeout = val;
                CFG_RETRY_LIMIT:  cfg.retry_limit = val[3:0];
                CFG_J1939_GRACE:  cfg.j1939_grace = val;
                CFG_J1939_LISTEN: cfg.j1939_listen = val;
                default: ;
            endcase
        endfunction

        // A match only holds if J1939 was heard or the trial is an ISO variant.
        function void declare_link();
            if (j1939_hit || (trial >= PROTO_11_250 && trial <= PROTO_29_500))
                link = LINK_MATCHED;
            else
                link = LINK_FAILED;
        endfunction

        function void bump_wait();
            if (wait_cnt != WAIT_MAX) wait_cnt++;
        endfunction

        // At the retry limit: next ISO variant, or a decided link after J1939 or the last one.
        function void advance_variant();
            if (trial == PROTO_11_250) begin
                trial = PROTO_29_250;
                baud = 1'b0;
                phase = PH_INIT;
            end else if (trial == PROTO_29_250) begin
                if (j1939_hit) begin
                    trial = PROTO_NONE;
                    declare_link();
                end else begin
                    trial = PROTO_11_500;
                    baud = 1'b1;
                    phase = PH_INIT;
                end
            end else if (trial == PROTO_11_500) begin
                trial = PROTO_29_500;
                baud = 1'b1;
                phase = PH_INIT;
            end else begin
                link = LINK_FAILED;
            end
        endfunction

        // Notes one accepted input transaction and queues the status it causes.
        function void take_item(item_t it);
            logic       only_mode;
            logic       pgn_hit;
            logic [1:0] prev_link;
            result_t    r;
            only_mode = cfg.only_j1939_cfg | learned_only;
            prev_link = link;
            r = '0;
            n_items++;

            if (it.op == OP_RESTART) begin
                clear_seq();
            end else if (link == LINK_MATCHING && it.op == OP_TICK) begin
                case (phase)
                    PH_INIT: begin
                        if (only_mode) baud = 1'b0;
                        r.baud_program = 1'b1;
                        tmo_cnt = '0;
                        reply_hit = 1'b0;
                        phase = (trial == PROTO_11_250) ? PH_LISTEN : PH_SEND;
                    end
                    PH_SEND: begin
                        if (!only_mode) begin
                            r.send_request = 1'b1;
                            r.request_extended =
                                !(trial == PROTO_11_250 || trial == PROTO_11_500);
                        end
                        phase = PH_WAIT;
                        wait_cnt = '0;
                    end
                    PH_WAIT: begin
                        if (reply_hit) begin
                            // At 250k a reply still leaves room for J1939 to show up.
                            if (!baud && !j1939_hit) begin
                                bump_wait();
                                if (wait_cnt > cfg.j1939_grace) declare_link();
                            end else begin
                                declare_link();
                            end
                        end else if (wait_cnt > cfg.reply_timeout) begin
                            if (tmo_cnt != TIMEOUT_MAX) tmo_cnt++;
                            if (tmo_cnt >= cfg.retry_limit)
                                advance_variant();
                            else
                                phase = PH_SEND;
                        end else begin
                            bump_wait();
                        end
                    end
                    default: begin
                        bump_wait();
                        if (wait_cnt > cfg.j1939_listen) begin
                            tmo_cnt = '0;
                            reply_hit = 1'b0;
                            phase = PH_SEND;
                        end
                    end
                endcase
            end else if (link == LINK_MATCHING && it.op == OP_FRAME && it.from_obd_port) begin
                pgn_hit = !baud && it.frame_extended && (it.frame_id[23:8] == PGN_F004);
                if (phase == PH_WAIT) begin
                    if (pgn_hit) j1939_hit = 1'b1;
                    if (it.data_byte1 == SVC_MODE01_OK && it.data_byte2 == PID_SUPPORTED &&
                        !(it.frame_extended && it.id_blacklisted)) begin
                        wait_cnt = '0;
                        reply_hit = 1'b1;
                    end
                end else if (phase == PH_LISTEN && pgn_hit) begin
                    j1939_hit = 1'b1;
                    trial = PROTO_NONE;
                    learned_only = 1'b1;
                    declare_link();
                end
            end

            if (prev_link == LINK_MATCHING && link == LINK_MATCHED) n_matched++;
            if (prev_link == LINK_MATCHING && link == LINK_FAILED) n_failed++;
            if (r.send_request) n_requests++;

            r.link_status = link;
            r.detected_protocol = (link == LINK_MATCHED) ?
                                  (j1939_hit ? PROTO_J1939 : trial) : PROTO_NONE;
            r.baud_is_500 = baud;
            status_due.push_back(r);
        endfunction

        // Compares one result transaction with the oldest expected status.
        function void check_status(result_t got);
            result_t exp;
            string   diff;
            n_results++;
            if (status_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result %0d arrived with no transaction outstanding", n_results);
                return;
            end
            exp = status_due.pop_front();
            diff = "";
            if (got.link_status !== exp.link_status) diff = {diff, " link_status"};
            if (got.detected_protocol !== exp.detected_protocol)
                diff = {diff, " detected_protocol"};
            if (got.baud_is_500 !== exp.baud_is_500) diff = {diff, " baud_is_500"};
            if (got.baud_program !== exp.baud_program) diff = {diff, " baud_program"};
            if (got.send_request !== exp.send_request) diff = {diff, " send_request"};
            if (got.request_extended !== exp.request_extended)
                diff = {diff, " request_extended"};
            if (diff != "") begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Result %0d differs in%s: expected link=%0d proto=%0d b500=%0d",
                              " prog=%0d req=%0d ext=%0d, got link=%0d proto=%0d b500=%0d",
                              " prog=%0d req=%0d ext=%0d"},
                             n_results, diff, exp.link_status, exp.detected_protocol,
                             exp.baud_is_500, exp.baud_program, exp.send_request,
                             exp.request_extended, got.link_status, got.detected_protocol,
                             got.baud_is_500, got.baud_program, got.send_request,
                             got.request_extended);
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    item_t                s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b1;
    result_t              m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data = '0;

    protocol_tracker tracker;
    int unsigned     burst_left = 0;
    int unsigned     n_settings = 0;
    ready_mode_t     ready_mode = RDY_ALWAYS;
    int unsigned     mode_left = 0;
    int unsigned     ready_phase = 0;

    obd_can_protocol_detector_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial forever #1 aclk = ~aclk;

    // Result side: check every accepted transaction, then pick the next ready value.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_status(m_data);
        if (mode_left == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            mode_left <= $urandom_range(16, 96);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            RDY_ALWAYS: m_ready <= 1'b1;
            RDY_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
            RDY_THIRD:  m_ready <= (ready_phase % 3 == 0);
            default:    m_ready <= 1'($urandom_range(0, 1));
        endcase
        ready_phase <= ready_phase + 1;
    end

    // Watchdog on the whole run.
    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("Mismatches found");
        $finish;
    end

    function automatic item_t make_item(logic [1:0] op, logic port, logic [28:0] id,
                                        logic ext, logic [7:0] b1, logic [7:0] b2,
                                        logic black);
        item_t it;
        it.op = op;
        it.from_obd_port = port;
        it.frame_id = id;
        it.frame_extended = ext;
        it.data_byte1 = b1;
        it.data_byte2 = b2;
        it.id_blacklisted = black;
        return it;
    endfunction

    // Mostly ticks and frames; replies and F004 frames are planted often enough
    // to drive the sequence into every match and timeout path.
    function automatic item_t random_item(int unsigned restart_pm);
        item_t       it;
        int unsigned roll;
        int unsigned kind;
        it.op = OP_TICK;
        it.from_obd_port = ($urandom_range(0, 9) != 0);
        it.frame_id = 29'($urandom());
        it.frame_extended = 1'($urandom_range(0, 1));
        it.data_byte1 = 8'($urandom());
        it.data_byte2 = 8'($urandom());
        it.id_blacklisted = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 999);
        if (roll < restart_pm) begin
            it.op = OP_RESTART;
        end else if (roll < restart_pm + 10) begin
            it.op = OP_UNUSED;
        end else if (roll >= 560) begin
            it.op = OP_FRAME;
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                it.data_byte1 = SVC_MODE01_OK;
                it.data_byte2 = PID_SUPPORTED;
            end else if (kind < 5) begin
                it.frame_id[23:8] = PGN_F004;
                if (kind == 3) it.frame_extended = 1'b1;
            end
        end
        return it;
    endfunction

    // Sends one input transaction; bursts end in a random gap.
    task automatic push_item(input item_t it);
        s_data <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        tracker.take_item(it);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(10, 20)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(20, 60);
            else
                burst_left = $urandom_range(0, 8);
        end
    endtask

    // Holds input off until every expected result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (tracker.status_due.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_reg(idx, val);
    endtask

    task automatic load_config(cfg_t c);
        write_reg(CFG_ONLY_J1939, {7'd0, c.only_j1939_cfg});
        write_reg(CFG_REPLY_TMO, c.reply_timeout);
        write_reg(CFG_RETRY_LIMIT, {4'd0, c.retry_limit});
        write_reg(CFG_J1939_GRACE, c.j1939_grace);
        write_reg(CFG_J1939_LISTEN, c.j1939_listen);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Random traffic; every accepted transaction counts toward the total.
    task automatic run_random(int unsigned count, int unsigned restart_pm);
        int unsigned used;
        bit          held;
        used = 0;
        held = 1'b0;
        while (used < count) begin
            push_item(random_item(restart_pm));
            used++;
            if (!held && used >= count / 2) begin
                held = 1'b1;
                drain_results();
            end
        end
        drain_results();
    endtask

    initial begin
        cfg_t rnd_cfg;
        int unsigned errors;
        tracker = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset configuration.
        push_item(make_item(OP_UNUSED, 1'b1, '1, 1'b1, 8'hFF, 8'hFF, 1'b1));
        push_item(make_item(OP_FRAME, 1'b1, '1, 1'b1, 8'hFF, 8'hFF, 1'b1));
        push_item(make_item(OP_TICK, 1'b0, '0, 1'b0, 8'h00, 8'h00, 1'b0));
        push_item(make_item(OP_FRAME, 1'b0, {5'h1F, PGN_F004, 8'hFF}, 1'b1, 8'h00, 8'h00,
                            1'b0));
        push_item(make_item(OP_FRAME, 1'b1, {5'h00, PGN_F004, 8'h00}, 1'b0, 8'h00, 8'h00,
                            1'b0));
        push_item(make_item(OP_FRAME, 1'b1, 29'h7E8, 1'b0, SVC_MODE01_OK, PID_SUPPORTED,
                            1'b0));
        push_item(make_item(OP_FRAME, 1'b1, {5'h00, PGN_F004, 8'h00}, 1'b1, 8'h00, 8'h00,
                            1'b0));
        push_item(make_item(OP_TICK, 1'b1, '1, 1'b1, 8'hFF, 8'hFF, 1'b1));
        push_item(make_item(OP_FRAME, 1'b1, 29'h7E8, 1'b0, SVC_MODE01_OK, PID_SUPPORTED,
                            1'b0));
        push_item(make_item(OP_RESTART, 1'b1, '1, 1'b1, 8'hFF, 8'hFF, 1'b1));
        push_item(make_item(OP_TICK, 1'b0, '0, 1'b0, 8'h00, 8'h00, 1'b0));
        push_item(make_item(OP_RESTART, 1'b0, '0, 1'b0, 8'h00, 8'h00, 1'b0));
        drain_results();

        // Short windows and a retry limit of one.
        load_config('{1'b0, 8'd3, 4'd1, 8'd4, 8'd3});
        run_random(250, 15);

        // J1939-only mode with every timer at zero and no retries.
        load_config('{1'b1, 8'd0, 4'd0, 8'd0, 8'd0});
        run_random(150, 20);

        // Maximum retries with one-tick windows.
        load_config('{1'b0, 8'd1, 4'd15, 8'd1, 8'd1});
        run_random(150, 10);

        // Saturating timers that never expire.
        load_config('{1'b0, 8'd255, 4'd15, 8'd255, 8'd255});
        run_random(200, 6);

        // A random small setting.
        rnd_cfg.only_j1939_cfg = ($urandom_range(0, 3) == 0);
        rnd_cfg.reply_timeout = 8'($urandom_range(0, 6));
        rnd_cfg.retry_limit = 4'($urandom_range(0, 4));
        rnd_cfg.j1939_grace = 8'($urandom_range(0, 6));
        rnd_cfg.j1939_listen = 8'($urandom_range(0, 6));
        load_config(rnd_cfg);
        run_random(250, 15);

        repeat (4) @(posedge aclk);
        errors = tracker.mismatches + tracker.status_due.size();
        $display("Sent %0d input transactions under %0d register settings plus reset values;",
                 tracker.n_items, n_settings);
        $display("checked %0d results: %0d links matched, %0d failed, %0d requests raised.",
                 tracker.n_results, tracker.n_matched, tracker.n_failed, tracker.n_requests);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
